// ===== rtl/core/htw_pkg.sv =====
// Shared constants, opcodes and sequencer state type for the hashed timer wheel.
// No dependencies.
package htw_pkg;

    localparam int BUCKETS = 64;
    localparam int SLOTS   = 32;
    localparam int BKT_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int LINK_W  = 6;
    localparam int ROT_W   = 26;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 6;

    // link value that marks end of list / list head / empty bucket
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_U_RD   = 12'b0000_0000_0010,
        ST_U_WR   = 12'b0000_0000_0100,
        ST_A_SUM  = 12'b0000_0000_1000,
        ST_A_DEC  = 12'b0000_0001_0000,
        ST_A_LINK = 12'b0000_0010_0000,
        ST_A_FIN  = 12'b0000_0100_0000,
        ST_T_INC  = 12'b0000_1000_0000,
        ST_T_HEAD = 12'b0001_0000_0000,
        ST_T_RD   = 12'b0010_0000_0000,
        ST_T_PROC = 12'b0100_0000_0000,
        ST_T_END  = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== rtl/core/htw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/htw_alu.sv =====
// Shared 32-bit adder used for bucket sums, decrements and tick advance.
// Depends on htw_pkg.
module htw_alu (
    input  logic [htw_pkg::DATA_W-1:0] a,
    input  logic [htw_pkg::DATA_W-1:0] b,
    output logic [htw_pkg::DATA_W-1:0] sum
);

    // modulo 2^32 add; a decrement is an add of all ones
    assign sum = a + b;

endmodule

// ===== rtl/core/hashed_timer_wheel.sv =====
// Hashed timer wheel: sequencer, link stores and result register.
// Depends on htw_pkg, htw_ram, htw_alu.
// An add of an active slot first unlinks it; a rejected add or cancel is answered from idle.
// A tick visits the entries of its bucket one at a time, at most 32 per tick.
// busy drops as the last result is shown, so the next item can follow; receiver cannot stall.
// Reset clears the tick counter, bucket valid bits and slot active bits.
module hashed_timer_wheel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [htw_pkg::SLOT_W-1:0]  timer_slot,
    input  logic [htw_pkg::DATA_W-1:0]  expiry_delay,
    output logic                        strobe,
    output logic                        status,
    output logic                        fired,
    output logic [htw_pkg::SLOT_W-1:0]  fired_slot,
    output logic [htw_pkg::CNT_W-1:0]   fire_total,
    output logic                        last
);

    localparam int LW = htw_pkg::LINK_W;
    localparam int SW = htw_pkg::SLOT_W;
    localparam int BW = htw_pkg::BKT_W;
    localparam int RW = htw_pkg::ROT_W;
    localparam int DW = htw_pkg::DATA_W;
    localparam int CW = htw_pkg::CNT_W;

    htw_pkg::state_t state_reg, state_next;

    logic [1:0]             op_reg;
    logic [SW-1:0]          slot_reg;
    logic [DW-1:0]          delay_reg;
    logic [DW-1:0]          tick_reg, tick_next;
    logic [BW-1:0]          bkt_reg, bkt_next;
    logic [LW-1:0]          h_reg, h_next;
    logic [RW-1:0]          rot_reg, rot_next;
    logic [LW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          guard_reg, guard_next;
    logic [CW-1:0]          k_reg, k_next;
    logic                   pend_reg, pend_next;
    logic [SW-1:0]          pslot_reg, pslot_next;
    logic [CW-1:0]          pcnt_reg, pcnt_next;
    logic [htw_pkg::SLOTS-1:0]   active_reg, active_next;
    logic [htw_pkg::BUCKETS-1:0] hv_reg, hv_next;
    logic                   hv_q;

    // result register
    logic          strobe_reg, strobe_next;
    logic          status_reg, status_next;
    logic          fired_reg, fired_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic          last_reg, last_next;

    // memory ports
    logic          nx_we, pv_we, rt_we, hm_we, hd_we;
    logic [SW-1:0] nx_wa, pv_wa, rt_wa, hm_wa, lk_ra;
    logic [LW-1:0] nx_wd, pv_wd, hd_wd;
    logic [RW-1:0] rt_wd;
    logic [BW-1:0] hm_wd, hd_wa, hd_ra;
    logic [LW-1:0] nx_rd, pv_rd, hd_rd;
    logic [RW-1:0] rt_rd;
    logic [BW-1:0] hm_rd;

    logic [DW-1:0] alu_a, alu_b, alu_sum;
    logic [LW-1:0] head_val;
    logic [CW-1:0] guard_inc;

    htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::SLOTS)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(lk_ra), .rdata(nx_rd));
    htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::SLOTS)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(lk_ra), .rdata(pv_rd));
    htw_ram #(.WIDTH(RW), .DEPTH(htw_pkg::SLOTS)) u_rot (
        .clk(clk), .we(rt_we), .waddr(rt_wa), .wdata(rt_wd), .raddr(lk_ra), .rdata(rt_rd));
    htw_ram #(.WIDTH(BW), .DEPTH(htw_pkg::SLOTS)) u_home (
        .clk(clk), .we(hm_we), .waddr(hm_wa), .wdata(hm_wd), .raddr(lk_ra), .rdata(hm_rd));
    htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::BUCKETS)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));

    htw_alu u_alu (.a(alu_a), .b(alu_b), .sum(alu_sum));

    assign busy      = (state_reg != htw_pkg::ST_IDLE);
    assign head_val  = hv_q ? hd_rd : htw_pkg::NONE_LINK;
    assign guard_inc = guard_reg + CW'(1);
    assign lk_ra     = (state_reg == htw_pkg::ST_T_RD) ? cur_reg[SW-1:0] : slot_reg;
    assign hd_ra     = alu_sum[BW-1:0];

    // shared adder operand select
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            htw_pkg::ST_A_SUM:
            begin
                alu_a = tick_reg;
                alu_b = delay_reg;
            end
            htw_pkg::ST_A_DEC:
            begin
                alu_a = delay_reg;
                alu_b = '1;
            end
            htw_pkg::ST_T_INC:
            begin
                alu_a = tick_reg;
                alu_b = DW'(1);
            end
            htw_pkg::ST_T_PROC:
            begin
                alu_a = DW'(rt_rd);
                alu_b = '1;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        bkt_next    = bkt_reg;
        h_next      = h_reg;
        rot_next    = rot_reg;
        cur_next    = cur_reg;
        guard_next  = guard_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        pslot_next  = pslot_reg;
        pcnt_next   = pcnt_reg;
        active_next = active_reg;
        hv_next     = hv_reg;
        strobe_next = 1'b0;
        status_next = 1'b0;
        fired_next  = 1'b0;
        fslot_next  = '0;
        fcnt_next   = '0;
        last_next   = 1'b0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        rt_we = 1'b0; rt_wa = '0; rt_wd = '0;
        hm_we = 1'b0; hm_wa = '0; hm_wd = '0;
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0;

        case (state_reg)
            htw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        htw_pkg::OP_ADD:
                        begin
                            if (expiry_delay == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = 1'b1;
                                last_next   = 1'b1;
                            end
                            else if (active_reg[timer_slot])
                            begin
                                state_next = htw_pkg::ST_U_RD;
                            end
                            else
                            begin
                                state_next = htw_pkg::ST_A_SUM;
                            end
                        end
                        htw_pkg::OP_CANCEL:
                        begin
                            if (active_reg[timer_slot])
                            begin
                                state_next = htw_pkg::ST_U_RD;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                status_next = 1'b1;
                                last_next   = 1'b1;
                            end
                        end
                        htw_pkg::OP_TICK:
                        begin
                            state_next = htw_pkg::ST_T_INC;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                            status_next = 1'b1;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end

            // link reads for the slot are in flight
            htw_pkg::ST_U_RD:
            begin
                state_next = htw_pkg::ST_U_WR;
            end

            // unlink the slot from its bucket list
            htw_pkg::ST_U_WR:
            begin
                if (!pv_rd[LW-1])
                begin
                    nx_we = 1'b1; nx_wa = pv_rd[SW-1:0]; nx_wd = nx_rd;
                end
                else
                begin
                    hd_we = 1'b1; hd_wa = hm_rd; hd_wd = nx_rd;
                    hv_next[hm_rd] = 1'b1;
                end
                if (!nx_rd[LW-1])
                begin
                    pv_we = 1'b1; pv_wa = nx_rd[SW-1:0]; pv_wd = pv_rd;
                end
                active_next[slot_reg] = 1'b0;
                if (op_reg == htw_pkg::OP_ADD)
                begin
                    state_next = htw_pkg::ST_A_SUM;
                end
                else
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = htw_pkg::ST_IDLE;
                end
            end

            // target bucket; head read issued
            htw_pkg::ST_A_SUM:
            begin
                bkt_next   = alu_sum[BW-1:0];
                state_next = htw_pkg::ST_A_DEC;
            end

            // rotations = (delay - 1) / BUCKETS
            htw_pkg::ST_A_DEC:
            begin
                rot_next   = alu_sum[DW-1:BW];
                h_next     = head_val;
                state_next = htw_pkg::ST_A_LINK;
            end

            // push slot at the bucket head
            htw_pkg::ST_A_LINK:
            begin
                rt_we = 1'b1; rt_wa = slot_reg; rt_wd = rot_reg;
                hm_we = 1'b1; hm_wa = slot_reg; hm_wd = bkt_reg;
                nx_we = 1'b1; nx_wa = slot_reg; nx_wd = h_reg;
                hd_we = 1'b1; hd_wa = bkt_reg;  hd_wd = LW'(slot_reg);
                hv_next[bkt_reg] = 1'b1;
                if (!h_reg[LW-1])
                begin
                    pv_we = 1'b1; pv_wa = h_reg[SW-1:0]; pv_wd = LW'(slot_reg);
                end
                active_next[slot_reg] = 1'b1;
                state_next = htw_pkg::ST_A_FIN;
            end

            htw_pkg::ST_A_FIN:
            begin
                pv_we = 1'b1; pv_wa = slot_reg; pv_wd = htw_pkg::NONE_LINK;
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = htw_pkg::ST_IDLE;
            end

            // advance counter; head read issued
            htw_pkg::ST_T_INC:
            begin
                tick_next  = alu_sum;
                guard_next = '0;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = htw_pkg::ST_T_HEAD;
            end

            htw_pkg::ST_T_HEAD:
            begin
                cur_next = head_val;
                if (head_val[LW-1])
                begin
                    state_next = htw_pkg::ST_T_END;
                end
                else
                begin
                    state_next = htw_pkg::ST_T_RD;
                end
            end

            htw_pkg::ST_T_RD:
            begin
                state_next = htw_pkg::ST_T_PROC;
            end

            // visit one entry: count down or fire
            htw_pkg::ST_T_PROC:
            begin
                guard_next = guard_inc;
                if (rt_rd != '0)
                begin
                    rt_we = 1'b1; rt_wa = cur_reg[SW-1:0]; rt_wd = alu_sum[RW-1:0];
                end
                else
                begin
                    if (!pv_rd[LW-1])
                    begin
                        nx_we = 1'b1; nx_wa = pv_rd[SW-1:0]; nx_wd = nx_rd;
                    end
                    else
                    begin
                        hd_we = 1'b1; hd_wa = hm_rd; hd_wd = nx_rd;
                        hv_next[hm_rd] = 1'b1;
                    end
                    if (!nx_rd[LW-1])
                    begin
                        pv_we = 1'b1; pv_wa = nx_rd[SW-1:0]; pv_wd = pv_rd;
                    end
                    active_next[cur_reg[SW-1:0]] = 1'b0;
                    // previous firing goes out now that another follows
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        fired_next  = 1'b1;
                        fslot_next  = pslot_reg;
                        fcnt_next   = pcnt_reg;
                    end
                    k_next     = k_reg + CW'(1);
                    pend_next  = 1'b1;
                    pslot_next = cur_reg[SW-1:0];
                    pcnt_next  = k_reg + CW'(1);
                end
                cur_next = nx_rd;
                if (nx_rd[LW-1] || (guard_inc == CW'(htw_pkg::SLOTS)))
                begin
                    state_next = htw_pkg::ST_T_END;
                end
                else
                begin
                    state_next = htw_pkg::ST_T_RD;
                end
            end

            htw_pkg::ST_T_END:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_reg)
                begin
                    fired_next = 1'b1;
                    fslot_next = pslot_reg;
                    fcnt_next  = pcnt_reg;
                end
                state_next = htw_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = htw_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= htw_pkg::ST_IDLE;
            tick_reg   <= '0;
            active_reg <= '0;
            hv_reg     <= '0;
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            active_reg <= active_next;
            hv_reg     <= hv_next;
            strobe_reg <= strobe_next;
            pend_reg   <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= opcode;
            slot_reg  <= timer_slot;
            delay_reg <= expiry_delay;
        end
        hv_q       <= hv_reg[hd_ra];
        bkt_reg    <= bkt_next;
        h_reg      <= h_next;
        rot_reg    <= rot_next;
        cur_reg    <= cur_next;
        guard_reg  <= guard_next;
        k_reg      <= k_next;
        pslot_reg  <= pslot_next;
        pcnt_reg   <= pcnt_next;
        status_reg <= status_next;
        fired_reg  <= fired_next;
        fslot_reg  <= fslot_next;
        fcnt_reg   <= fcnt_next;
        last_reg   <= last_next;
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign fired       = fired_reg;
    assign fired_slot  = fslot_reg;
    assign fire_total  = fcnt_reg;
    assign last        = last_reg;

endmodule
